// ===== rtl/psg_pkg.sv =====
package psg_pkg;

  localparam int TICK_W    = 16;
  localparam int LFSR_W    = 16;
  localparam int LEN_W     = 5;
  localparam int TONE_W    = 10;
  localparam int NCNT_W    = 7;
  localparam int ATTEN_W   = 4;
  localparam int VOICE_W   = 2;
  localparam int NUM_TONES = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int BYTE_W    = 8;

  localparam int READY_TICKS_DEF = 32;

  localparam logic [TICK_W-1:0] TICK_DIVIDE_RST = 16'd16;
  localparam logic [LFSR_W-1:0] TAP_MASK_RST    = 16'd9;
  localparam logic [LEN_W-1:0]  LFSR_LENGTH_RST = 5'd16;
  localparam logic [LFSR_W-1:0] LFSR_SEED_RST   = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_DIVIDE = 2'd0,
    CFG_TAP_MASK    = 2'd1,
    CFG_LFSR_LENGTH = 2'd2,
    CFG_LFSR_SEED   = 2'd3
  } cfg_index_t;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_TICK  = 1'b1
  } action_t;

  localparam logic [VOICE_W-1:0] VOICE_NOISE = 2'd3;

  typedef enum logic [1:0] {
    NRATE_16    = 2'd0,
    NRATE_32    = 2'd1,
    NRATE_64    = 2'd2,
    NRATE_VOICE = 2'd3
  } noise_rate_t;

  localparam logic [NCNT_W-1:0] NOISE_PERIOD_16 = 7'h10;
  localparam logic [NCNT_W-1:0] NOISE_PERIOD_32 = 7'h20;
  localparam logic [NCNT_W-1:0] NOISE_PERIOD_64 = 7'h40;

endpackage

// ===== rtl/psg_tone_noise_generator.sv =====
// Three square-wave tone voices and one noise voice driven by a shift register. Every
// accepted item (a command byte write or one clock tick) updates all voice state and
// produces one result, registered at the output; a new item is taken in every cycle as
// long as the result register is empty or being drained in the same cycle, so the
// sustained rate is one item per clock. The update path (prescaler, tone counters, noise
// counter and shift register step) is combinational. Configuration writes take effect at
// once and do not touch the voice state; the shift register takes the new seed only on a
// noise control write.
module psg_tone_noise_generator
  import psg_pkg::*;
#(
  parameter int READY_TICKS = READY_TICKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 action,
  input  logic [BYTE_W-1:0]    write_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 tone0_level,
  output logic                 tone1_level,
  output logic                 tone2_level,
  output logic                 noise_level,
  output logic [ATTEN_W-1:0]   atten0,
  output logic [ATTEN_W-1:0]   atten1,
  output logic [ATTEN_W-1:0]   atten2,
  output logic [ATTEN_W-1:0]   atten3,
  output logic                 busy_res
);

  localparam int READY_W = $clog2(READY_TICKS + 1);

  // Configuration registers.
  logic [TICK_W-1:0] tick_divide;
  logic [LFSR_W-1:0] noise_tap_mask;
  logic [LEN_W-1:0]  lfsr_length;
  logic [LFSR_W-1:0] lfsr_seed;

  // Voice state.
  logic [TONE_W-1:0]  tone_period [NUM_TONES];
  logic [TONE_W-1:0]  tone_count  [NUM_TONES];
  logic [NCNT_W-1:0]  noise_count;
  logic [ATTEN_W-1:0] voice_atten [4];
  logic [3:0]         voice_level;
  logic [NCNT_W-1:0]  noise_period;
  logic               white_mode;
  logic               noise_phase;
  logic               prev_trigger;
  logic [LFSR_W-1:0]  noise_lfsr;
  logic [VOICE_W-1:0] latched_voice;
  logic               latched_is_volume;
  logic [READY_W-1:0] ready_count;
  logic [TICK_W-1:0]  prescale_count;

  logic [TONE_W-1:0]  tone_period_next [NUM_TONES];
  logic [TONE_W-1:0]  tone_count_next  [NUM_TONES];
  logic [NCNT_W-1:0]  noise_count_next;
  logic [ATTEN_W-1:0] voice_atten_next [4];
  logic [3:0]         voice_level_next;
  logic [NCNT_W-1:0]  noise_period_next;
  logic               white_mode_next;
  logic               noise_phase_next;
  logic               prev_trigger_next;
  logic [LFSR_W-1:0]  noise_lfsr_next;
  logic [VOICE_W-1:0] latched_voice_next;
  logic               latched_is_volume_next;
  logic [READY_W-1:0] ready_count_next;
  logic [TICK_W-1:0]  prescale_count_next;

  logic              accept;
  logic [LEN_W-1:0]  len_eff;
  logic [LFSR_W-1:0] len_mask;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (lfsr_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (lfsr_length > LEN_W'(LFSR_W)) begin
      len_eff = LEN_W'(LFSR_W);
    end else begin
      len_eff = lfsr_length;
    end
    len_mask = ~(LFSR_W'({LFSR_W{1'b1}}) << len_eff);
  end

  // Shift one step: feedback enters at the top of the effective length.
  function automatic logic [LFSR_W-1:0] lfsr_step(
    input logic [LFSR_W-1:0] cur,
    input logic              white,
    input logic [LFSR_W-1:0] taps,
    input logic [LEN_W-1:0]  len,
    input logic [LFSR_W-1:0] mask
  );
    logic fb;
    fb = white ? ^(cur & taps) : cur[0];
    return ((cur >> 1) | (LFSR_W'(fb) << (len - LEN_W'(1)))) & mask;
  endfunction

  function automatic logic [NCNT_W-1:0] noise_rate(input logic [1:0] code);
    logic [NCNT_W-1:0] p;
    unique case (noise_rate_t'(code))
      NRATE_16:    p = NOISE_PERIOD_16;
      NRATE_32:    p = NOISE_PERIOD_32;
      NRATE_64:    p = NOISE_PERIOD_64;
      NRATE_VOICE: p = '0;
      default:     p = '0;
    endcase
    return p;
  endfunction

  always_comb begin
    logic do_noise_ctrl;
    logic trig;

    tone_period_next       = tone_period;
    tone_count_next        = tone_count;
    noise_count_next       = noise_count;
    voice_atten_next       = voice_atten;
    voice_level_next       = voice_level;
    noise_period_next      = noise_period;
    white_mode_next        = white_mode;
    noise_phase_next       = noise_phase;
    prev_trigger_next      = prev_trigger;
    noise_lfsr_next        = noise_lfsr;
    latched_voice_next     = latched_voice;
    latched_is_volume_next = latched_is_volume;
    ready_count_next       = ready_count;
    prescale_count_next    = prescale_count;
    do_noise_ctrl          = 1'b0;
    trig                   = 1'b0;

    if (action_t'(action) == ACT_WRITE) begin
      if (!write_byte[7]) begin
        if (!latched_is_volume) begin
          if (latched_voice == VOICE_NOISE) begin
            do_noise_ctrl = 1'b1;
          end else begin
            for (int i = 0; i < NUM_TONES; i++) begin
              if (latched_voice == VOICE_W'(i)) begin
                tone_period_next[i] = {write_byte[5:0], tone_period[i][3:0]};
              end
            end
          end
        end
      end else begin
        latched_voice_next     = write_byte[6:5];
        latched_is_volume_next = write_byte[4];
        if (write_byte[4]) begin
          for (int i = 0; i < 4; i++) begin
            if (write_byte[6:5] == VOICE_W'(i)) begin
              voice_atten_next[i] = write_byte[3:0];
            end
          end
        end else if (write_byte[6:5] == VOICE_NOISE) begin
          do_noise_ctrl = 1'b1;
        end else begin
          for (int i = 0; i < NUM_TONES; i++) begin
            if (write_byte[6:5] == VOICE_W'(i)) begin
              tone_period_next[i] = {tone_period[i][TONE_W-1:4], write_byte[3:0]};
            end
          end
        end
      end
      if (do_noise_ctrl) begin
        white_mode_next   = write_byte[2];
        noise_period_next = noise_rate(write_byte[1:0]);
        noise_count_next  = noise_rate(write_byte[1:0]);
        noise_lfsr_next   = lfsr_seed & len_mask;
      end
      ready_count_next = READY_W'(READY_TICKS);
    end else begin
      if (ready_count != '0) begin
        ready_count_next = ready_count - READY_W'(1);
      end
      if (prescale_count <= TICK_W'(1)) begin
        prescale_count_next = tick_divide;
        for (int i = 0; i < NUM_TONES; i++) begin
          if (tone_period[i] <= TONE_W'(1)) begin
            voice_level_next[i] = 1'b1;
          end else if (tone_count[i] <= TONE_W'(1)) begin
            tone_count_next[i]  = tone_period[i];
            voice_level_next[i] = !voice_level[i];
          end else begin
            tone_count_next[i] = tone_count[i] - TONE_W'(1);
          end
        end
        if (noise_period == '0) begin
          // Noise clocked by rising edges of tone voice 2, after its own step.
          trig = voice_level_next[2];
          if (!prev_trigger && trig) begin
            noise_lfsr_next = lfsr_step(noise_lfsr, white_mode, noise_tap_mask,
                                        len_eff, len_mask);
            voice_level_next[3] = noise_lfsr_next[0];
          end
          prev_trigger_next = trig;
        end else if (noise_count <= NCNT_W'(1)) begin
          noise_count_next = noise_period;
          noise_phase_next = !noise_phase;
          if (!noise_phase) begin
            noise_lfsr_next = lfsr_step(noise_lfsr, white_mode, noise_tap_mask,
                                        len_eff, len_mask);
            voice_level_next[3] = noise_lfsr_next[0];
          end
        end else begin
          noise_count_next = noise_count - NCNT_W'(1);
        end
      end else begin
        prescale_count_next = prescale_count - TICK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_divide    <= TICK_DIVIDE_RST;
      noise_tap_mask <= TAP_MASK_RST;
      lfsr_length    <= LFSR_LENGTH_RST;
      lfsr_seed      <= LFSR_SEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_TICK_DIVIDE: tick_divide    <= cfg_data[TICK_W-1:0];
        CFG_TAP_MASK:    noise_tap_mask <= cfg_data[LFSR_W-1:0];
        CFG_LFSR_LENGTH: lfsr_length    <= cfg_data[LEN_W-1:0];
        CFG_LFSR_SEED:   lfsr_seed      <= cfg_data[LFSR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TONES; i++) begin
        tone_period[i] <= '0;
        tone_count[i]  <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        voice_atten[i] <= '0;
      end
      noise_count       <= '0;
      voice_level       <= '0;
      noise_period      <= '0;
      white_mode        <= 1'b0;
      noise_phase       <= 1'b0;
      prev_trigger      <= 1'b0;
      noise_lfsr        <= LFSR_SEED_RST;
      latched_voice     <= '0;
      latched_is_volume <= 1'b0;
      ready_count       <= '0;
      prescale_count    <= TICK_DIVIDE_RST;
    end else if (accept) begin
      tone_period       <= tone_period_next;
      tone_count        <= tone_count_next;
      voice_atten       <= voice_atten_next;
      noise_count       <= noise_count_next;
      voice_level       <= voice_level_next;
      noise_period      <= noise_period_next;
      white_mode        <= white_mode_next;
      noise_phase       <= noise_phase_next;
      prev_trigger      <= prev_trigger_next;
      noise_lfsr        <= noise_lfsr_next;
      latched_voice     <= latched_voice_next;
      latched_is_volume <= latched_is_volume_next;
      ready_count       <= ready_count_next;
      prescale_count    <= prescale_count_next;
    end
  end

  // Result register: loaded with the state as it stands after the item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tone0_level <= voice_level_next[0];
      tone1_level <= voice_level_next[1];
      tone2_level <= voice_level_next[2];
      noise_level <= voice_level_next[3];
      atten0      <= voice_atten_next[0];
      atten1      <= voice_atten_next[1];
      atten2      <= voice_atten_next[2];
      atten3      <= voice_atten_next[3];
      busy_res    <= (ready_count_next != '0);
    end
  end

endmodule

// ===== rtl/psg_checker.sv =====
module psg_checker
  import psg_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 action,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 tone0_level,
  input logic                 noise_level,
  input logic [ATTEN_W-1:0]   atten0,
  input logic [ATTEN_W-1:0]   atten3,
  input logic                 busy_res
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tone0_level) && $stable(noise_level)
      && $stable(atten0) && $stable(busy_res))
    else $error("result changed while stalled");

  // Every accepted item yields a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  // A command write always arms the ready countdown.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action == ACT_WRITE |=> busy_res)
    else $error("write did not raise busy");

  // Ticks never rearm the countdown or touch attenuations.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action == ACT_TICK && out_valid |=>
      (!busy_res || $past(busy_res)) && atten0 == $past(atten0) && atten3 == $past(atten3))
    else $error("tick changed busy or attenuation");

endmodule

bind psg_tone_noise_generator psg_checker u_psg_checker (.*);

// ===== tb/psg_result_checker.sv =====
`timescale 1ns / 1ps

module psg_result_checker
  import psg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  action_t              action,
  input  logic [BYTE_W-1:0]    write_byte,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 tone0_level,
  input  logic                 tone1_level,
  input  logic                 tone2_level,
  input  logic                 noise_level,
  input  logic [ATTEN_W-1:0]   atten0,
  input  logic [ATTEN_W-1:0]   atten1,
  input  logic [ATTEN_W-1:0]   atten2,
  input  logic [ATTEN_W-1:0]   atten3,
  input  logic                 busy_res,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct {
    logic               tone0;
    logic               tone1;
    logic               tone2;
    logic               noise;
    logic [ATTEN_W-1:0] att0;
    logic [ATTEN_W-1:0] att1;
    logic [ATTEN_W-1:0] att2;
    logic [ATTEN_W-1:0] att3;
    logic               busy;
  } psg_snapshot_t;

  psg_snapshot_t snapshot_q[$];

  // Register copies.
  logic [TICK_W-1:0] tick_divide_cfg;
  logic [LFSR_W-1:0] tap_mask_cfg;
  logic [LEN_W-1:0]  lfsr_len_cfg;
  logic [LFSR_W-1:0] seed_cfg;

  // Voice state.
  logic [TONE_W-1:0]  period_r [NUM_TONES];
  logic [TICK_W-1:0]  count_r [4];
  logic [ATTEN_W-1:0] atten_r [4];
  logic               level_r [4];
  logic [NCNT_W-1:0]  noise_period_r;
  logic               white_r;
  logic               noise_phase_r;
  logic               prev_trig_r;
  logic [LFSR_W-1:0]  lfsr_r;
  logic [VOICE_W-1:0] latch_voice_r;
  logic               latch_vol_r;
  logic [5:0]         ready_r;
  logic [TICK_W-1:0]  prescale_r;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // A length of zero behaves as one bit, anything past sixteen as sixteen.
  function automatic int lfsr_bits();
    if (lfsr_len_cfg == 0) return 1;
    if (lfsr_len_cfg > LFSR_W) return LFSR_W;
    return int'(lfsr_len_cfg);
  endfunction

  function automatic logic [LFSR_W-1:0] lfsr_mask();
    logic [31:0] m;
    m = (32'd1 << lfsr_bits()) - 32'd1;
    return m[LFSR_W-1:0];
  endfunction

  function automatic void shift_noise();
    logic              fb;
    logic [LFSR_W-1:0] fb_word;
    fb = white_r ? ^(lfsr_r & tap_mask_cfg) : lfsr_r[0];
    fb_word = '0;
    fb_word[lfsr_bits() - 1] = fb;
    lfsr_r = ((lfsr_r >> 1) | fb_word) & lfsr_mask();
    level_r[3] = lfsr_r[0];
  endfunction

  function automatic void reload_noise(input logic [BYTE_W-1:0] b);
    white_r = b[2];
    case (noise_rate_t'(b[1:0]))
      NRATE_16: noise_period_r = NOISE_PERIOD_16;
      NRATE_32: noise_period_r = NOISE_PERIOD_32;
      NRATE_64: noise_period_r = NOISE_PERIOD_64;
      default:  noise_period_r = '0;
    endcase
    count_r[3] = TICK_W'(noise_period_r);
    lfsr_r = seed_cfg & lfsr_mask();
  endfunction

  function automatic void apply_write(input logic [BYTE_W-1:0] b);
    if (!b[7]) begin
      // A data byte only counts when a period or noise setting is latched.
      if (!latch_vol_r) begin
        if (latch_voice_r != VOICE_NOISE) period_r[latch_voice_r][9:4] = b[5:0];
        else reload_noise(b);
      end
    end else begin
      latch_voice_r = b[6:5];
      latch_vol_r = b[4];
      if (latch_vol_r) atten_r[latch_voice_r] = b[3:0];
      else if (latch_voice_r != VOICE_NOISE) period_r[latch_voice_r][3:0] = b[3:0];
      else reload_noise(b);
    end
    ready_r = 6'(READY_TICKS_DEF);
  endfunction

  function automatic void step_voices();
    logic trig;
    for (int i = 0; i < NUM_TONES; i++) begin
      if (period_r[i] <= 1) begin
        level_r[i] = 1'b1;
      end else if (count_r[i] <= 1) begin
        count_r[i] = TICK_W'(period_r[i]);
        level_r[i] = ~level_r[i];
      end else begin
        count_r[i] = count_r[i] - 1'b1;
      end
    end
    if (noise_period_r == 0) begin
      trig = level_r[2];
      if (!prev_trig_r && trig) shift_noise();
      prev_trig_r = trig;
    end else if (count_r[3] <= 1) begin
      count_r[3] = TICK_W'(noise_period_r);
      noise_phase_r = ~noise_phase_r;
      if (noise_phase_r) shift_noise();
    end else begin
      count_r[3] = count_r[3] - 1'b1;
    end
  endfunction

  function automatic void advance_tick();
    if (ready_r != 0) ready_r = ready_r - 1'b1;
    if (prescale_r <= 1) begin
      prescale_r = tick_divide_cfg;
      step_voices();
    end else begin
      prescale_r = prescale_r - 1'b1;
    end
  endfunction

  function automatic void reset_model();
    tick_divide_cfg = TICK_DIVIDE_RST;
    tap_mask_cfg    = TAP_MASK_RST;
    lfsr_len_cfg    = LFSR_LENGTH_RST;
    seed_cfg        = LFSR_SEED_RST;
    for (int i = 0; i < NUM_TONES; i++) period_r[i] = '0;
    for (int i = 0; i < 4; i++) begin
      count_r[i] = '0;
      atten_r[i] = '0;
      level_r[i] = 1'b0;
    end
    noise_period_r = '0;
    white_r        = 1'b0;
    noise_phase_r  = 1'b0;
    prev_trig_r    = 1'b0;
    lfsr_r         = seed_cfg & lfsr_mask();
    latch_voice_r  = '0;
    latch_vol_r    = 1'b0;
    ready_r        = '0;
    prescale_r     = tick_divide_cfg;
  endfunction

  function automatic psg_snapshot_t current_snapshot();
    psg_snapshot_t s;
    s.tone0 = level_r[0];
    s.tone1 = level_r[1];
    s.tone2 = level_r[2];
    s.noise = level_r[3];
    s.att0  = atten_r[0];
    s.att1  = atten_r[1];
    s.att2  = atten_r[2];
    s.att3  = atten_r[3];
    s.busy  = (ready_r != 0);
    return s;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    psg_snapshot_t want;
    if (rst) begin
      reset_model();
      snapshot_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_TICK_DIVIDE: tick_divide_cfg = cfg_data;
          CFG_TAP_MASK:    tap_mask_cfg = cfg_data;
          CFG_LFSR_LENGTH: lfsr_len_cfg = cfg_data[LEN_W-1:0];
          CFG_LFSR_SEED:   seed_cfg = cfg_data;
          default: ;
        endcase
      end
      // The output is registered, so a result leaving now was predicted at an earlier edge.
      if (out_valid && out_ready) begin
        if (snapshot_q.size() == 0) begin
          $error("result transfer with no prediction pending");
          mismatches++;
        end else begin
          want = snapshot_q.pop_front();
          check_field("tone0_level", want.tone0, tone0_level);
          check_field("tone1_level", want.tone1, tone1_level);
          check_field("tone2_level", want.tone2, tone2_level);
          check_field("noise_level", want.noise, noise_level);
          check_field("atten0", want.att0, atten0);
          check_field("atten1", want.att1, atten1);
          check_field("atten2", want.att2, atten2);
          check_field("atten3", want.att3, atten3);
          check_field("busy_res", want.busy, busy_res);
        end
      end
      if (in_valid && in_ready) begin
        if (action == ACT_TICK) advance_tick();
        else apply_write(write_byte);
        snapshot_q.push_back(current_snapshot());
      end
    end
    outstanding = snapshot_q.size();
  end

endmodule

// ===== tb/tb_psg_tone_noise_generator.sv =====
`timescale 1ns / 1ps

module tb_psg_tone_noise_generator;
  import psg_pkg::*;

  localparam logic KIND_VOLUME    = 1'b1;
  localparam logic KIND_DATA      = 1'b0;
  localparam int   STALL_LIMIT    = 3000;
  localparam int   RX_HOLD_CYCLES = 400;
  localparam int   SETTLE_CYCLES  = 4;
  localparam int   PHASE_ITEMS    = 200;
  localparam int   NUM_PHASES     = 6;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  action_t              action;
  logic [BYTE_W-1:0]    write_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic                 tone0_level;
  logic                 tone1_level;
  logic                 tone2_level;
  logic                 noise_level;
  logic [ATTEN_W-1:0]   atten0;
  logic [ATTEN_W-1:0]   atten1;
  logic [ATTEN_W-1:0]   atten2;
  logic [ATTEN_W-1:0]   atten3;
  logic                 busy_res;
  int                   mismatches;
  int                   outstanding;

  bit tx_calm;
  bit rx_calm;
  bit hold_req;
  int stall_cycles;

  psg_tone_noise_generator DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .write_byte  (write_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .tone0_level (tone0_level),
    .tone1_level (tone1_level),
    .tone2_level (tone2_level),
    .noise_level (noise_level),
    .atten0      (atten0),
    .atten1      (atten1),
    .atten2      (atten2),
    .atten3      (atten3),
    .busy_res    (busy_res)
  );

  psg_result_checker u_result_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .write_byte  (write_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .tone0_level (tone0_level),
    .tone1_level (tone1_level),
    .tone2_level (tone2_level),
    .noise_level (noise_level),
    .atten0      (atten0),
    .atten1      (atten1),
    .atten2      (atten2),
    .atten3      (atten3),
    .busy_res    (busy_res),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [BYTE_W-1:0] latch_cmd(input logic [VOICE_W-1:0] voice,
                                                  input logic kind, input logic [3:0] low);
    return {1'b1, voice, kind, low};
  endfunction

  function automatic logic [BYTE_W-1:0] data_cmd(input logic [5:0] high);
    return {2'b00, high};
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic push_item(input action_t act, input logic [BYTE_W-1:0] b);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    write_byte <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_cfg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_random(output int n);
    int                 r;
    logic [VOICE_W-1:0] voice;
    logic [TONE_W-1:0]  period;
    r = $urandom_range(0, 99);
    n = 1;
    if (r < 58) begin
      push_item(ACT_TICK, 8'($urandom_range(0, 255)));
    end else if (r < 78) begin
      // Full period program: latch with the low bits, then the high bits.
      voice = 2'($urandom_range(0, NUM_TONES - 1));
      if ($urandom_range(0, 3) == 0) period = 10'($urandom_range(0, 1023));
      else period = 10'($urandom_range(0, 24));
      push_item(ACT_WRITE, latch_cmd(voice, KIND_DATA, period[3:0]));
      push_item(ACT_WRITE, data_cmd(period[9:4]));
      n = 2;
    end else if (r < 86) begin
      voice = 2'($urandom_range(0, 3));
      push_item(ACT_WRITE, latch_cmd(voice, KIND_VOLUME, 4'($urandom_range(0, 15))));
    end else if (r < 93) begin
      push_item(ACT_WRITE, latch_cmd(VOICE_NOISE, KIND_DATA, 4'($urandom_range(0, 15))));
      if ($urandom_range(0, 2) == 0) begin
        push_item(ACT_WRITE, data_cmd(6'($urandom_range(0, 63))));
        n = 2;
      end
    end else begin
      push_item(ACT_WRITE, 8'($urandom_range(0, 255)));
    end
  endtask

  // Receiver side: random back-pressure, plus one long hold on request.
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end else begin
        gap = pick_gap(rx_calm);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_psg_tone_noise_generator NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int quota;
    int k;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = CFG_TICK_DIVIDE;
    cfg_data   = '0;
    in_valid   = 1'b0;
    action     = ACT_WRITE;
    write_byte = '0;
    tx_calm    = 1'b0;
    rx_calm    = 1'b0;
    hold_req   = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under the reset register values.
    push_item(ACT_WRITE, latch_cmd(2'd0, KIND_VOLUME, 4'hF));
    push_item(ACT_WRITE, latch_cmd(2'd1, KIND_VOLUME, 4'h0));
    push_item(ACT_WRITE, latch_cmd(2'd2, KIND_VOLUME, 4'h5));
    push_item(ACT_WRITE, latch_cmd(VOICE_NOISE, KIND_VOLUME, 4'hA));
    // Data byte while a volume is latched is dropped but still sets busy.
    push_item(ACT_WRITE, data_cmd(6'h3F));
    push_item(ACT_WRITE, latch_cmd(2'd0, KIND_DATA, 4'hF));
    push_item(ACT_WRITE, data_cmd(6'h3F));
    push_item(ACT_WRITE, latch_cmd(2'd1, KIND_DATA, 4'h1));
    push_item(ACT_WRITE, data_cmd(6'h00));
    push_item(ACT_WRITE, latch_cmd(VOICE_NOISE, KIND_DATA, {1'b0, 1'b1, NRATE_16}));
    // Noise reprogrammed through a data byte: white noise clocked by voice 2.
    push_item(ACT_WRITE, data_cmd({3'b000, 1'b1, NRATE_VOICE}));
    for (int i = 0; i < 17; i++) push_item(ACT_TICK, (i % 2) ? 8'hFF : 8'h00);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          write_cfg(CFG_TICK_DIVIDE, 16'd1);
          write_cfg(CFG_TAP_MASK, 16'h0003);
          write_cfg(CFG_LFSR_LENGTH, 16'd16);
          write_cfg(CFG_LFSR_SEED, 16'h0001);
        end
        1: begin
          // Zero divide and zero length both act as one.
          write_cfg(CFG_TICK_DIVIDE, 16'd0);
          write_cfg(CFG_TAP_MASK, 16'hFFFF);
          write_cfg(CFG_LFSR_LENGTH, 16'd0);
          write_cfg(CFG_LFSR_SEED, 16'hFFFF);
        end
        2: begin
          write_cfg(CFG_TICK_DIVIDE, 16'd2);
          write_cfg(CFG_TAP_MASK, 16'($urandom_range(0, 65535)));
          write_cfg(CFG_LFSR_LENGTH, 16'd31);
          write_cfg(CFG_LFSR_SEED, 16'h0000);
        end
        3: begin
          write_cfg(CFG_TICK_DIVIDE, 16'hFFFF);
          write_cfg(CFG_TAP_MASK, 16'h0000);
          write_cfg(CFG_LFSR_LENGTH, 16'd1);
          write_cfg(CFG_LFSR_SEED, 16'($urandom_range(0, 65535)));
        end
        default: begin
          write_cfg(CFG_TICK_DIVIDE, 16'($urandom_range(1, 4)));
          write_cfg(CFG_TAP_MASK, 16'($urandom_range(0, 65535)));
          write_cfg(CFG_LFSR_LENGTH, 16'($urandom_range(0, 65535)));
          write_cfg(CFG_LFSR_SEED, 16'($urandom_range(0, 65535)));
        end
      endcase

      // The slowest divide steps only once, so that phase stays short.
      quota = (phase == 3) ? 60 : PHASE_ITEMS + 28;
      sent = 0;
      while (sent < quota) begin
        if (phase == 0 && sent >= 20 && sent < 22 && !tx_calm) begin
          // Keep offering items while the receiver holds off, so the block backs up.
          tx_calm = 1'b1;
          hold_req = 1'b1;
        end
        if (phase == 0 && sent >= 40 && sent < 42) tx_calm = 1'b0;
        if (!(phase == 0 && sent < 42) && $urandom_range(0, 39) == 0) tx_calm = ~tx_calm;
        if ($urandom_range(0, 39) == 0) rx_calm = ~rx_calm;
        send_random(k);
        sent += k;
      end
    end

    wait_idle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_psg_tone_noise_generator OK");
    end else begin
      $display("tb_psg_tone_noise_generator NOT OK");
    end
    $finish;
  end

endmodule
